### rtl/core/ptsel_pkg.sv
package ptsel_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int EDGE_W = $clog2(MAX_EDGES);
    localparam int LINK_W = $clog2(MAX_EDGES + 1);
    localparam int COST_W = 32;
    localparam int KEY_W  = COST_W + NODE_W;
    localparam int CFG_W  = 11;

    localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(MAX_EDGES);

    localparam logic [1:0] ACT_COST  = 2'd0;
    localparam logic [1:0] ACT_EDGE  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    localparam logic ADDR_NODE_COUNT = 1'b0;
    localparam logic ADDR_REQ_COUNT  = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [9:0]  node;
        logic [9:0]  prerequisite;
        logic [31:0] cost;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] max_cost;
        logic        ran_short;
        logic        edge_overflow;
    } out_beat_t;

    typedef struct packed {
        logic             clear;
        logic             push;
        logic             pop;
        logic [KEY_W-1:0] key;
    } heap_cmd_t;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] size;
        logic [KEY_W-1:0] top;
    } heap_stat_t;

endpackage

### rtl/core/ptsel_ram.sv
module ptsel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/ptsel_heap.sv
module ptsel_heap (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptsel_pkg::heap_cmd_t  cmd,
    output ptsel_pkg::heap_stat_t stat
);
    import ptsel_pkg::*;

    localparam logic [2:0] H_IDLE     = 3'd0;
    localparam logic [2:0] H_UP_ISSUE = 3'd1;
    localparam logic [2:0] H_UP_CMP   = 3'd2;
    localparam logic [2:0] H_P_TOP    = 3'd3;
    localparam logic [2:0] H_P_LAST   = 3'd4;
    localparam logic [2:0] H_DN_ISSUE = 3'd5;
    localparam logic [2:0] H_DN_L     = 3'd6;
    localparam logic [2:0] H_DN_R     = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  size_reg, size_next;
    logic [NODE_W-1:0] pos_reg, pos_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KEY_W-1:0]  lkey_reg, lkey_next;
    logic [KEY_W-1:0]  top_reg, top_next;

    logic              we;
    logic [NODE_W-1:0] waddr, raddr;
    logic [KEY_W-1:0]  wdata, rdata;

    logic [NODE_W-1:0] parent;
    logic [CNT_W-1:0]  left, right;
    logic [KEY_W-1:0]  min_lk;

    ptsel_ram #(.WIDTH(KEY_W), .DEPTH(MAX_NODES)) u_heap_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign parent = NODE_W'((pos_reg - NODE_W'(1)) >> 1);
    assign left   = {pos_reg, 1'b1};
    assign right  = left + CNT_W'(1);
    assign min_lk = (lkey_reg < key_reg) ? lkey_reg : key_reg;

    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        lkey_next  = lkey_reg;
        top_next   = top_reg;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = key_reg;
        raddr      = '0;
        case (state_reg)
            H_IDLE:
            begin
                if (cmd.clear)
                begin
                    size_next = '0;
                end
                else if (cmd.push)
                begin
                    if (size_reg < CNT_W'(MAX_NODES))
                    begin
                        pos_next   = size_reg[NODE_W-1:0];
                        key_next   = cmd.key;
                        size_next  = size_reg + CNT_W'(1);
                        state_next = H_UP_ISSUE;
                    end
                end
                else if (cmd.pop)
                begin
                    raddr      = '0;
                    size_next  = size_reg - CNT_W'(1);
                    state_next = H_P_TOP;
                end
            end
            H_UP_ISSUE:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    raddr      = parent;
                    state_next = H_UP_CMP;
                end
            end
            H_UP_CMP:
            begin
                we = 1'b1;
                if (rdata <= key_reg)
                begin
                    state_next = H_IDLE;
                end
                else
                begin
                    wdata      = rdata;
                    pos_next   = parent;
                    state_next = H_UP_ISSUE;
                end
            end
            H_P_TOP:
            begin
                top_next = rdata;
                if (size_reg == '0)
                begin
                    state_next = H_IDLE;
                end
                else
                begin
                    raddr      = size_reg[NODE_W-1:0];
                    state_next = H_P_LAST;
                end
            end
            H_P_LAST:
            begin
                key_next   = rdata;
                pos_next   = '0;
                state_next = H_DN_ISSUE;
            end
            H_DN_ISSUE:
            begin
                if (left >= size_reg)
                begin
                    we         = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    raddr      = left[NODE_W-1:0];
                    state_next = H_DN_L;
                end
            end
            H_DN_L:
            begin
                lkey_next = rdata;
                if (right < size_reg)
                begin
                    raddr      = right[NODE_W-1:0];
                    state_next = H_DN_R;
                end
                else
                begin
                    we = 1'b1;
                    if (rdata < key_reg)
                    begin
                        wdata      = rdata;
                        pos_next   = left[NODE_W-1:0];
                        state_next = H_DN_ISSUE;
                    end
                    else
                    begin
                        state_next = H_IDLE;
                    end
                end
            end
            H_DN_R:
            begin
                we = 1'b1;
                if (rdata < min_lk)
                begin
                    wdata      = rdata;
                    pos_next   = right[NODE_W-1:0];
                    state_next = H_DN_ISSUE;
                end
                else if (lkey_reg < key_reg)
                begin
                    wdata      = lkey_reg;
                    pos_next   = left[NODE_W-1:0];
                    state_next = H_DN_ISSUE;
                end
                else
                begin
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        key_reg  <= key_next;
        lkey_reg <= lkey_next;
        top_reg  <= top_next;
    end

    assign stat.idle = (state_reg == H_IDLE);
    assign stat.size = size_reg;
    assign stat.top  = top_reg;

endmodule

### rtl/core/ptsel_engine.sv
module ptsel_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  ptsel_pkg::in_beat_t    item,
    input  logic [10:0]            node_count,
    input  logic [10:0]            required_count,
    input  logic                   slot_free,
    output logic                   ready,
    output logic                   res_valid,
    output ptsel_pkg::out_beat_t   res
);
    import ptsel_pkg::*;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_EDGE2   = 4'd2;
    localparam logic [3:0] S_COPY_RD = 4'd3;
    localparam logic [3:0] S_COPY_WR = 4'd4;
    localparam logic [3:0] S_SEL     = 4'd5;
    localparam logic [3:0] S_POPW    = 4'd6;
    localparam logic [3:0] S_HEAD    = 4'd7;
    localparam logic [3:0] S_ECHK    = 4'd8;
    localparam logic [3:0] S_ETGT    = 4'd9;
    localparam logic [3:0] S_WORK    = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LINK_W-1:0] fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic [COST_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0]  taken_reg, taken_next;
    logic              short_reg, short_next;
    logic [LINK_W-1:0] link_reg, link_next;
    logic [LINK_W-1:0] steps_reg, steps_next;
    logic [LINK_W-1:0] nxt_reg, nxt_next;
    logic [NODE_W-1:0] dep_reg, dep_next;
    in_beat_t          item_reg, item_next;

    // store ports
    logic              cost_we, deg_we, head_we, edge_we, work_we;
    logic [NODE_W-1:0] cost_wa, cost_ra, deg_wa, deg_ra, head_wa, head_ra;
    logic [NODE_W-1:0] work_wa, work_ra;
    logic [EDGE_W-1:0] edge_ra;
    logic [COST_W-1:0] cost_rd;
    logic [LINK_W-1:0] deg_wd, deg_rd, head_wd, head_rd, work_wd, work_rd, next_rd;
    logic [NODE_W-1:0] tgt_rd;

    heap_cmd_t         hcmd;
    heap_stat_t        hstat;
    logic [CNT_W-1:0]  limit;
    logic [COST_W-1:0] top_cost;

    ptsel_ram #(.WIDTH(COST_W), .DEPTH(MAX_NODES)) u_cost_ram (
        .clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(item_reg.cost),
        .raddr(cost_ra), .rdata(cost_rd)
    );
    ptsel_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_deg_ram (
        .clk(clk), .we(deg_we), .waddr(deg_wa), .wdata(deg_wd),
        .raddr(deg_ra), .rdata(deg_rd)
    );
    ptsel_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_head_ram (
        .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
        .raddr(head_ra), .rdata(head_rd)
    );
    ptsel_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_tgt_ram (
        .clk(clk), .we(edge_we), .waddr(fill_reg[EDGE_W-1:0]), .wdata(item_reg.node),
        .raddr(edge_ra), .rdata(tgt_rd)
    );
    ptsel_ram #(.WIDTH(LINK_W), .DEPTH(MAX_EDGES)) u_next_ram (
        .clk(clk), .we(edge_we), .waddr(fill_reg[EDGE_W-1:0]), .wdata(head_rd),
        .raddr(edge_ra), .rdata(next_rd)
    );
    ptsel_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_work_ram (
        .clk(clk), .we(work_we), .waddr(work_wa), .wdata(work_wd),
        .raddr(work_ra), .rdata(work_rd)
    );

    ptsel_heap u_heap (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (hcmd),
        .stat (hstat)
    );

    assign limit    = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;
    assign top_cost = hstat.top[KEY_W-1:NODE_W];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        best_next  = best_reg;
        taken_next = taken_reg;
        short_next = short_reg;
        link_next  = link_reg;
        steps_next = steps_reg;
        nxt_next   = nxt_reg;
        dep_next   = dep_reg;
        item_next  = item_reg;

        cost_we = 1'b0;  cost_wa = item_reg.node;  cost_ra = tgt_rd;
        deg_we  = 1'b0;  deg_wa  = cnt_reg[NODE_W-1:0];
        deg_wd  = '0;    deg_ra  = cnt_reg[NODE_W-1:0];
        head_we = 1'b0;  head_wa = cnt_reg[NODE_W-1:0];
        head_wd = EMPTY_LINK;
        head_ra = hstat.top[NODE_W-1:0];
        edge_we = 1'b0;  edge_ra = link_reg[EDGE_W-1:0];
        work_we = 1'b0;  work_wa = dep_reg;
        work_wd = work_rd - LINK_W'(1);
        work_ra = tgt_rd;

        hcmd       = '0;
        hcmd.key   = {cost_rd, dep_reg};
        ready      = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                deg_we  = 1'b1;
                head_we = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ready   = 1'b1;
                deg_ra  = item.node;
                head_ra = item.prerequisite;
                if (item_valid)
                begin
                    item_next = item;
                    case (item.action)
                        ACT_COST:
                        begin
                            state_next = S_EDGE2;
                        end
                        ACT_EDGE:
                        begin
                            if (fill_reg >= LINK_W'(MAX_EDGES))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_EDGE2;
                            end
                        end
                        ACT_START:
                        begin
                            hcmd.clear = 1'b1;
                            cnt_next   = '0;
                            best_next  = '0;
                            taken_next = '0;
                            short_next = 1'b0;
                            state_next = S_COPY_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EDGE2:
            begin
                // cost loads and edge loads both finish here
                state_next = S_IDLE;
                if (item_reg.action == ACT_COST)
                begin
                    cost_we = 1'b1;
                end
                else
                begin
                    edge_we   = 1'b1;
                    head_we   = 1'b1;
                    head_wa   = item_reg.prerequisite;
                    head_wd   = fill_reg;
                    deg_we    = 1'b1;
                    deg_wa    = item_reg.node;
                    deg_wd    = deg_rd + LINK_W'(1);
                    fill_next = fill_reg + LINK_W'(1);
                end
            end
            S_COPY_RD:
            begin
                cost_ra = cnt_reg[NODE_W-1:0];
                if (hstat.idle)
                begin
                    state_next = S_COPY_WR;
                end
            end
            S_COPY_WR:
            begin
                work_we  = 1'b1;
                work_wa  = cnt_reg[NODE_W-1:0];
                work_wd  = deg_rd;
                hcmd.key = {cost_rd, cnt_reg[NODE_W-1:0]};
                if ((cnt_reg < limit) && (deg_rd == '0))
                begin
                    hcmd.push = 1'b1;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAX_NODES - 1))
                begin
                    state_next = S_SEL;
                end
                else
                begin
                    state_next = S_COPY_RD;
                end
            end
            S_SEL:
            begin
                if (hstat.idle)
                begin
                    if (taken_reg >= required_count)
                    begin
                        state_next = S_DONE;
                    end
                    else if (hstat.size == '0)
                    begin
                        short_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        hcmd.pop   = 1'b1;
                        state_next = S_POPW;
                    end
                end
            end
            S_POPW:
            begin
                if (hstat.idle)
                begin
                    if (top_cost > best_reg)
                    begin
                        best_next = top_cost;
                    end
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                link_next  = head_rd;
                steps_next = '0;
                state_next = S_ECHK;
            end
            S_ECHK:
            begin
                if (hstat.idle)
                begin
                    if ((link_reg < LINK_W'(MAX_EDGES)) && (steps_reg < LINK_W'(MAX_EDGES)))
                    begin
                        state_next = S_ETGT;
                    end
                    else
                    begin
                        taken_next = taken_reg + CNT_W'(1);
                        state_next = S_SEL;
                    end
                end
            end
            S_ETGT:
            begin
                dep_next   = tgt_rd;
                nxt_next   = next_rd;
                state_next = S_WORK;
            end
            S_WORK:
            begin
                if (work_rd != '0)
                begin
                    work_we = 1'b1;
                    if (work_rd == LINK_W'(1))
                    begin
                        hcmd.push = 1'b1;
                    end
                end
                link_next  = nxt_reg;
                steps_next = steps_reg + LINK_W'(1);
                state_next = S_ECHK;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // cost and work reads in S_ETGT use the target just read; keep those
    // addresses pinned in S_WORK so the data stays put
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            taken_reg <= '0;
            short_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            taken_reg <= taken_next;
            short_reg <= short_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg  <= best_next;
        link_reg  <= link_next;
        steps_reg <= steps_next;
        nxt_reg   <= nxt_next;
        dep_reg   <= dep_next;
        item_reg  <= item_next;
    end

    assign res.max_cost      = best_reg;
    assign res.ran_short     = short_reg;
    assign res.edge_overflow = ovf_reg;

endmodule

### rtl/core/prioritized_topological_selection_core.sv
// Prioritized topological selection. Load beats write a node cost or a
// dependency edge (first read the list head and in-degree, then write
// them back); neither gives a result. A start beat copies the
// in-degrees into a scratch store while seeding a min-heap (cost, then
// node index) with ready nodes below node_count, then pops the cheapest
// node required_count times, walking its edge list and releasing
// dependents, and returns one result beat: the largest cost taken, a flag
// if the heap ran dry first, and a sticky flag if any edge was dropped
// because the edge store was full. A start sweeps all MAX_NODES
// entries in the copy, then each push and pop walks the heap level by
// level and each edge in the list is walked in turn. After reset the
// block clears all MAX_NODES (1024) entries of the in-degree and
// list-head stores and holds stall high meanwhile; register writes are
// taken at any time.
module prioritized_topological_selection_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ptsel_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ptsel_pkg::out_beat_t out_data
);
    import ptsel_pkg::*;

    logic [CFG_W-1:0] node_count_reg;
    logic [CFG_W-1:0] req_count_reg;
    logic             cfg_write;

    logic             eng_ready;
    logic             res_valid;
    out_beat_t        res;
    logic             in_accept;

    logic             out_valid_reg, out_valid_next;
    out_beat_t        out_data_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == ADDR_REQ_COUNT) ? {{(32-CFG_W){1'b0}}, req_count_reg}
                                                    : {{(32-CFG_W){1'b0}}, node_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
            req_count_reg  <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ADDR_NODE_COUNT)
            begin
                node_count_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                req_count_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // sequencer owns every store; it takes a beat only when idle
    assign in_stall  = !eng_ready;
    assign in_accept = in_valid && eng_ready;

    ptsel_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (in_accept),
        .item          (in_data),
        .node_count    (node_count_reg),
        .required_count(req_count_reg),
        .slot_free     (!out_valid_reg),
        .ready         (eng_ready),
        .res_valid     (res_valid),
        .res           (res)
    );

    // result holding register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a result is only produced into an empty slot
    a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !out_valid_reg)
        else $error("result produced while slot full");

    // a result beat leaves the sequencer for one cycle only
    a_res_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> !res_valid)
        else $error("result pulse longer than one cycle");

    // no input beat is taken while a result is being handed over
    a_accept_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> !res_valid)
        else $error("input taken during result handover");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import ptsel_pkg::*;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int SETTLE = 20;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Topological selection predictor and queue of pending answers
    class selection_scoreboard;
        logic [31:0] cost_mem[MAX_NODES];
        bit          costed[MAX_NODES];
        int unsigned indeg[MAX_NODES];
        int unsigned head[MAX_NODES];
        int unsigned work[MAX_NODES];
        int unsigned tgt[MAX_EDGES];
        int unsigned nxt[MAX_EDGES];
        int unsigned fill;
        bit          ovf;
        logic [KEY_W-1:0] hp[MAX_NODES];
        int unsigned hsize;
        int unsigned node_cnt;
        int unsigned req_cnt;
        out_beat_t   answers[$];
        int          errors;

        function new();
            foreach (head[i])
            begin
                head[i] = MAX_EDGES;
                indeg[i] = 0;
                costed[i] = 0;
                cost_mem[i] = '0;
            end
            fill = 0;
            ovf = 0;
            node_cnt = 0;
            req_cnt = 0;
            errors = 0;
        endfunction

        function void set_reg(bit idx, int unsigned val);
            if (idx == ADDR_NODE_COUNT)
                node_cnt = val & 'h7FF;
            else
                req_cnt = val & 'h7FF;
        endfunction

        function void heap_push(int unsigned n, ref int unsigned missing[$]);
            int unsigned i;
            int unsigned p;
            logic [KEY_W-1:0] t;
            if (!costed[n])
                missing.insert(missing.size(), n);
            if (hsize >= MAX_NODES)
                return;
            i = hsize;
            hsize++;
            hp[i] = {cost_mem[n], n[NODE_W-1:0]};
            while (i > 0)
            begin
                p = (i - 1) / 2;
                if (hp[p] <= hp[i])
                    break;
                t = hp[p];
                hp[p] = hp[i];
                hp[i] = t;
                i = p;
            end
        endfunction

        function logic [KEY_W-1:0] heap_pop();
            logic [KEY_W-1:0] top;
            logic [KEY_W-1:0] t;
            int unsigned i;
            int unsigned l;
            int unsigned r;
            int unsigned m;
            top = hp[0];
            hsize--;
            hp[0] = hp[hsize];
            i = 0;
            forever
            begin
                l = 2 * i + 1;
                r = l + 1;
                m = i;
                if (l < hsize && hp[l] < hp[m])
                    m = l;
                if (r < hsize && hp[r] < hp[m])
                    m = r;
                if (m == i)
                    break;
                t = hp[m];
                hp[m] = hp[i];
                hp[i] = t;
                i = m;
            end
            return top;
        endfunction

        // Kahn's walk; also lists nodes entering the heap without a loaded cost
        function out_beat_t select_max(ref int unsigned missing[$]);
            out_beat_t r;
            int unsigned lim;
            int unsigned taken;
            int unsigned e;
            int unsigned d;
            int unsigned steps;
            logic [KEY_W-1:0] key;
            r = '0;
            lim = (node_cnt > MAX_NODES) ? MAX_NODES : node_cnt;
            work = indeg;
            hsize = 0;
            taken = 0;
            for (int unsigned n = 0; n < lim; n++)
                if (work[n] == 0)
                    heap_push(n, missing);
            while (taken < req_cnt)
            begin
                if (hsize == 0)
                begin
                    r.ran_short = 1'b1;
                    break;
                end
                key = heap_pop();
                if (key[KEY_W-1:NODE_W] > r.max_cost)
                    r.max_cost = key[KEY_W-1:NODE_W];
                e = head[key[NODE_W-1:0]];
                steps = 0;
                while (e < MAX_EDGES && steps < MAX_EDGES)
                begin
                    d = tgt[e];
                    if (work[d] > 0)
                    begin
                        work[d]--;
                        if (work[d] == 0)
                            heap_push(d, missing);
                    end
                    e = nxt[e];
                    steps++;
                end
                taken++;
            end
            r.edge_overflow = ovf;
            return r;
        endfunction

        function void note_beat(in_beat_t b);
            int unsigned miss[$];
            case (b.action)
                ACT_COST:
                begin
                    cost_mem[b.node] = b.cost;
                    costed[b.node] = 1;
                end
                ACT_EDGE:
                begin
                    if (fill >= MAX_EDGES)
                        ovf = 1;
                    else
                    begin
                        tgt[fill] = b.node;
                        nxt[fill] = head[b.prerequisite];
                        head[b.prerequisite] = fill;
                        fill++;
                        indeg[b.node]++;
                    end
                end
                ACT_START:
                    answers.insert(answers.size(), select_max(miss));
                default: ;
            endcase
        endfunction

        function void check_beat(out_beat_t got);
            out_beat_t want;
            if (answers.size() == 0)
            begin
                $error("result beat with nothing pending: %h", got);
                errors++;
                return;
            end
            want = answers.pop_front();
            if (got.max_cost !== want.max_cost)
            begin
                $error("max_cost: expected %h, got %h", want.max_cost, got.max_cost);
                errors++;
            end
            if (got.ran_short !== want.ran_short)
            begin
                $error("ran_short: expected %b, got %b", want.ran_short, got.ran_short);
                errors++;
            end
            if (got.edge_overflow !== want.edge_overflow)
            begin
                $error("edge_overflow: expected %b, got %b",
                       want.edge_overflow, got.edge_overflow);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_beat_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    out_beat_t   out_data;

    selection_scoreboard sb = new();

    int in_idle_pct = 0;    // chance per cycle that the sender holds back
    int out_idle_pct = 0;   // chance per cycle that the receiver stalls
    int hold_req = 0;       // long receiver hold-off, counted by the receiver
    int unsigned cycles = 0;

    prioritized_topological_selection_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: covers the reset clear sweep, big starts and long stalls
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("prioritized_topological_selection_core verification failed");
            $finish;
        end
    end

    // Receiver: random stall, plus the long hold-off when requested
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else if (hold_req > 0)
        begin
            out_stall <= 1'b1;
            hold_req <= hold_req - 1;
        end
        else
            out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // Result beats are checked at the edge that takes them
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_beat(out_data);

    // Register write: setup then access; written at the access edge
    task automatic reg_write(bit idx, int unsigned val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // One input beat; returns once the block has taken it (at a falling edge)
    task automatic send_beat(in_beat_t b);
        while ($urandom_range(99) < in_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        in_data = b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_beat(b);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic load_cost(int unsigned n, logic [31:0] c);
        in_beat_t b;
        b = '0;
        b.action = ACT_COST;
        b.node = NODE_W'(n);
        b.prerequisite = NODE_W'($urandom);
        b.cost = c;
        send_beat(b);
    endtask

    task automatic load_edge(int unsigned dep, int unsigned pre);
        in_beat_t b;
        b = '0;
        b.action = ACT_EDGE;
        b.node = NODE_W'(dep);
        b.prerequisite = NODE_W'(pre);
        b.cost = $urandom;
        send_beat(b);
    endtask

    // Any node that would enter the heap without a cost gets one first
    task automatic start_select();
        int unsigned miss[$];
        out_beat_t   dummy;
        in_beat_t    b;
        forever
        begin
            miss.delete();
            dummy = sb.select_max(miss);
            if (miss.size() == 0)
                break;
            foreach (miss[i])
                load_cost(miss[i], $urandom);
        end
        b.action = ACT_START;
        b.node = NODE_W'($urandom);
        b.prerequisite = NODE_W'($urandom);
        b.cost = $urandom;
        send_beat(b);
    endtask

    task automatic drain();
        while (sb.answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic int unsigned pick_node();
        return ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(63);
    endfunction

    function automatic logic [31:0] pick_cost();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_beat();
        in_beat_t b;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            load_cost(pick_node(), pick_cost());
        else if (r < 80)
            load_edge(pick_node(), pick_node());
        else if (r < 95)
            start_select();
        else
        begin
            // unused action code, must be ignored
            b.action = ACT_UNUSED;
            b.node = NODE_W'($urandom);
            b.prerequisite = NODE_W'($urandom);
            b.cost = $urandom;
            send_beat(b);
        end
    endtask

    function automatic int unsigned pick_count();
        case ($urandom_range(11))
            0: return 0;
            1: return 1024;
            2: return 2047;
            3: return $urandom_range(2047);
            default: return $urandom_range(1, 70);
        endcase
    endfunction

    // node_count stays small so few nodes need a cost before a start
    function automatic int unsigned pick_nodes();
        return ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 70);
    endfunction

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, cost ties, released node past node_count,
        // ignored action, zero required, repeated start, heap running dry
        reg_write(ADDR_NODE_COUNT, 0);
        reg_write(ADDR_REQ_COUNT, 0);
        load_cost(0, 32'h0);
        load_cost(1023, 32'hFFFF_FFFF);
        load_cost(1, 32'h5555_AAAA);
        load_cost(2, 32'hAAAA_5555);
        load_cost(3, 32'h0);
        load_edge(1023, 0);
        load_edge(2, 1);
        load_edge(682, 341);
        load_cost(341, 32'h1);
        load_cost(682, 32'h2);
        send_beat('{action: ACT_UNUSED, node: 10'h3FF, prerequisite: 10'h3FF, cost: '1});
        start_select();
        drain();
        reg_write(ADDR_NODE_COUNT, 4);
        reg_write(ADDR_REQ_COUNT, 5);
        start_select();
        start_select();
        drain();
        reg_write(ADDR_REQ_COUNT, 2047);
        start_select();
        drain();
        reg_write(ADDR_NODE_COUNT, 40);
        reg_write(ADDR_REQ_COUNT, 3);
        start_select();
        drain();

        // Long receiver hold-off while starts pile up behind it
        reg_write(ADDR_NODE_COUNT, 8);
        reg_write(ADDR_REQ_COUNT, 8);
        hold_req = 3000;
        repeat (4) start_select();
        repeat (6) load_edge(pick_node(), pick_node());
        drain();

        // Random phases: sender-light/receiver-heavy, reversed, then free-running
        for (int ph = 0; ph < 8; ph++)
        begin
            in_idle_pct = (ph < 3) ? 10 : (ph < 6) ? 86 : 0;
            out_idle_pct = (ph < 3) ? 86 : (ph < 6) ? 10 : 0;
            reg_write(ADDR_NODE_COUNT, (ph == 7) ? 64 : pick_nodes());
            reg_write(ADDR_REQ_COUNT, (ph == 7) ? 2047 : pick_count());
            repeat (45) random_beat();
            drain();
        end

        in_idle_pct = 0;
        out_idle_pct = 0;
        reg_write(ADDR_NODE_COUNT, 64);
        reg_write(ADDR_REQ_COUNT, 1024);
        start_select();
        drain();
        reg_write(ADDR_NODE_COUNT, 16);
        reg_write(ADDR_REQ_COUNT, 4);
        start_select();
        drain();

        repeat (100) @(negedge clk);
        if (sb.answers.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.answers.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("prioritized_topological_selection_core verification clean");
        else
            $display("prioritized_topological_selection_core verification failed");
        $finish;
    end
endmodule
